### rtl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared widths, reset values, register codes, the configuration struct and
// the sequencer states of the stereo box-filter downsampler.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int unsigned DEF_FRAC_BITS = 16;

  localparam int unsigned IN_W    = 16;
  localparam int unsigned S_W     = IN_W + 1;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned RATIO_W = 24;
  localparam int unsigned INV_W   = 25;
  localparam int unsigned SUM_W   = 42;
  localparam int unsigned LO_W    = 21;
  localparam int unsigned HI_W    = SUM_W - LO_W;
  localparam int unsigned MA_W    = LO_W + 1;

  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [RATIO_W-1:0] RATIO_RST = 24'd180634;
  localparam logic [INV_W-1:0]   INV_RST   = 25'd6087064;

  localparam logic REG_RATIO = 1'b0;
  localparam logic REG_INV   = 1'b1;

  localparam int unsigned NEG_LIMIT = 32768;
  localparam int unsigned POS_LIMIT = 32767;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio_q16;
    logic [INV_W-1:0]   inv_ratio_q24;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MW1,
    S_ACC,
    S_ABS,
    S_MLO,
    S_MHI,
    S_MW2,
    S_FIN
  } state_t;

endpackage

### rtl/sbd_ifs.sv
// ----------------------------------------------------------------------------
// sbd_ifs
// Valid/ready channels of the downsampler: stereo frames in, mono samples out.
// ----------------------------------------------------------------------------
interface sbd_frame_if;
  logic                             valid;
  logic                             ready;
  logic signed [sbd_pkg::IN_W-1:0]  left;
  logic signed [sbd_pkg::IN_W-1:0]  right;

  modport source (output valid, output left, output right, input ready);
  modport sink (input valid, input left, input right, output ready);
endinterface

interface sbd_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [sbd_pkg::OUT_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### rtl/sbd_regs.sv
// ----------------------------------------------------------------------------
// sbd_regs
// APB-style register file holding the window ratio and its reciprocal.
// ----------------------------------------------------------------------------
module sbd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [sbd_pkg::DATA_W-1:0]  pwdata,
  output logic [sbd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output sbd_pkg::cfg_t               cfg
);
  import sbd_pkg::*;

  logic idx;

  assign idx    = paddr[2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ratio_q16     <= RATIO_RST;
      cfg.inv_ratio_q24 <= INV_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_RATIO: cfg.ratio_q16     <= pwdata[RATIO_W-1:0];
        REG_INV:   cfg.inv_ratio_q24 <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RATIO: prdata = DATA_W'(cfg.ratio_q16);
      REG_INV:   prdata = DATA_W'(cfg.inv_ratio_q24);
      default:   prdata = '0;
    endcase
  end

endmodule

### rtl/sbd_mul.sv
// ----------------------------------------------------------------------------
// sbd_mul
// Shared registered multiplier: signed operand times unsigned operand.
// ----------------------------------------------------------------------------
module sbd_mul #(
  parameter int unsigned A_W = sbd_pkg::MA_W,
  parameter int unsigned B_W = sbd_pkg::INV_W,
  parameter int unsigned P_W = A_W + B_W + 1
) (
  input  logic                  clk,
  input  logic signed [A_W-1:0] a,
  input  logic        [B_W-1:0] b,
  output logic signed [P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * $signed({1'b0, b});
  end

endmodule

### rtl/sbd_core.sv
// ----------------------------------------------------------------------------
// sbd_core
// Sequencer and datapath: weights each frame into the current window, and on
// a full window scales the sum by the reciprocal, rounds and saturates.
// ----------------------------------------------------------------------------
module sbd_core #(
  parameter int unsigned FRAC_BITS = sbd_pkg::DEF_FRAC_BITS,
  parameter int unsigned B_W       = sbd_pkg::INV_W,
  parameter int unsigned P_W       = sbd_pkg::MA_W + sbd_pkg::INV_W + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sbd_pkg::cfg_t               cfg,
  sbd_frame_if.sink                   frames,
  sbd_sample_if.source                samples,
  output logic signed [sbd_pkg::MA_W-1:0] mul_a,
  output logic [B_W-1:0]              mul_b,
  input  logic signed [P_W-1:0]       mul_p
);
  import sbd_pkg::*;

  localparam int unsigned WW    = FRAC_BITS + 1;
  localparam int unsigned FW    = (FRAC_BITS + 1 > RATIO_W) ? FRAC_BITS + 1 : RATIO_W;
  localparam int unsigned FW1   = FW + 1;
  localparam int unsigned SH    = FRAC_BITS + 25;
  localparam int unsigned TOT_W = SUM_W + INV_W + 1;
  localparam int unsigned Q_W   = TOT_W - SH;
  localparam logic [FW-1:0]    ONE  = FW'(1) << FRAC_BITS;
  localparam logic [TOT_W-1:0] HALF = TOT_W'(1) << (SH - 1);

  state_t state, state_next;

  logic signed [S_W-1:0]   s;
  logic [WW-1:0]           w1;
  logic [WW-1:0]           w2;
  logic [FW-1:0]           ratio_r;
  logic [FW-1:0]           fill;
  logic signed [SUM_W-1:0] sum;
  logic                    close;
  logic                    neg;
  logic [SUM_W-1:0]        mag;
  logic signed [P_W-1:0]   plo;
  logic [Q_W-1:0]          q;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_sample;

  logic [FW-1:0]           ratio_eff;
  logic [FW-1:0]           space;
  logic [WW-1:0]           w1_c;
  logic [FW1-1:0]          fill_sum;
  logic signed [SUM_W-1:0] sum_acc;
  logic [TOT_W-1:0]        tot;
  logic signed [OUT_W-1:0] sat;
  logic                    accept;
  logic                    out_free;
  logic                    load;
  logic                    in_ready;

  assign accept   = frames.valid && in_ready;
  assign out_free = !out_valid || samples.ready;

  assign frames.ready   = in_ready;
  assign samples.valid  = out_valid;
  assign samples.sample = out_sample;

  always_comb begin
    ratio_eff = (FW'(cfg.ratio_q16) < ONE) ? ONE : FW'(cfg.ratio_q16);
    space     = (ratio_eff > fill) ? ratio_eff - fill : '0;
    w1_c      = (space < ONE) ? WW'(space) : WW'(ONE);
    fill_sum  = {1'b0, fill} + FW1'(w1);
    sum_acc   = sum + SUM_W'(mul_p);
    tot       = (TOT_W'($unsigned(mul_p)) << LO_W) + TOT_W'($unsigned(plo)) + HALF;
    if (neg) begin
      sat = (q > Q_W'(NEG_LIMIT)) ? OUT_W'(NEG_LIMIT) : OUT_W'(Q_W'(0) - q);
    end else begin
      sat = (q > Q_W'(POS_LIMIT)) ? OUT_W'(POS_LIMIT) : OUT_W'(q);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_MW1;
      S_MW1:  state_next = S_ACC;
      S_ACC:  state_next = close ? S_ABS : S_IDLE;
      S_ABS:  state_next = S_MLO;
      S_MLO:  state_next = S_MHI;
      S_MHI:  state_next = S_MW2;
      S_MW2:  state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    mul_a    = MA_W'(s);
    mul_b    = B_W'(w1);
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_MLO: begin
        mul_a = $signed({1'b0, mag[LO_W-1:0]});
        mul_b = B_W'(cfg.inv_ratio_q24);
      end
      S_MHI: begin
        mul_a = $signed({1'b0, mag[SUM_W-1:LO_W]});
        mul_b = B_W'(cfg.inv_ratio_q24);
      end
      S_MW2: mul_b = B_W'(w2);
      S_FIN: begin
        mul_b = B_W'(w2);
        load  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (samples.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACC: begin
          sum <= sum_acc;
          if (!close) begin
            fill <= FW'(fill_sum);
          end
        end
        S_FIN: begin
          if (out_free) begin
            sum  <= SUM_W'(mul_p);
            fill <= FW'(w2);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s       <= S_W'(frames.left) + S_W'(frames.right);
      w1      <= w1_c;
      w2      <= WW'(ONE) - w1_c;
      ratio_r <= ratio_eff;
    end
    if (state == S_MW1) begin
      close <= (fill_sum >= {1'b0, ratio_r});
    end
    if (state == S_ABS) begin
      neg <= sum[SUM_W-1];
      mag <= sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);
    end
    if (state == S_MHI) begin
      plo <= mul_p;
    end
    if (state == S_MW2) begin
      q <= Q_W'(tot >> SH);
    end
    if (load) begin
      out_sample <= sat;
    end
  end

`ifndef SYNTH
  // A window that stays open never reaches its length.
  a_open_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && !close) |=> (fill < ratio_r))
    else $error("open window fill reached the ratio");

  // A new window starts with at most one frame of time.
  a_new_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (fill <= ONE))
    else $error("new window fill exceeds one frame");

  // A closing item waits while the output register is still full.
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !samples.ready) |=> (state == S_FIN))
    else $error("closing item left while output was full");

  // A result only appears from the final step of a closing item.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("output loaded outside the final step");
`endif

endmodule

### rtl/stereo_box_downsampler_top.sv
// ----------------------------------------------------------------------------
// stereo_box_downsampler_top
// Area-average downsampler: stereo frames in, saturated mono window means out.
//
//   Channel   Direction  Handshake        Payload
//   frames    in         valid / ready    left[15:0], right[15:0], signed
//   samples   out        valid / ready    sample[15:0], signed
//   APB       in         psel / penable   ratio_q16 at 0x0, inv_ratio_q24 at 0x4
//
// An item passes IDLE, MW1 and ACC when it leaves its window open, and also
// ABS, MLO, MHI, MW2 and FIN when it closes one; the single shared multiplier
// does the weighting and both halves of the output scaling, one product per cycle.
// Reset is synchronous and clears the window and restores register defaults.
// frames.ready is high only between items; a finished sample waits in the
// output register, and a closing item holds in its last step while it is full.
// ----------------------------------------------------------------------------
module stereo_box_downsampler_top #(
  parameter int unsigned FRAC_BITS = sbd_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [sbd_pkg::DATA_W-1:0]  pwdata,
  output logic [sbd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  sbd_frame_if.sink                   frames,
  sbd_sample_if.source                samples
);
  import sbd_pkg::*;

  localparam int unsigned B_W = (FRAC_BITS + 1 > INV_W) ? FRAC_BITS + 1 : INV_W;
  localparam int unsigned P_W = MA_W + B_W + 1;

  cfg_t                  cfg;
  logic signed [MA_W-1:0] mul_a;
  logic [B_W-1:0]        mul_b;
  logic signed [P_W-1:0] mul_p;

  sbd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbd_mul #(
    .A_W (MA_W),
    .B_W (B_W),
    .P_W (P_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  sbd_core #(
    .FRAC_BITS (FRAC_BITS),
    .B_W       (B_W),
    .P_W       (P_W)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .frames  (frames),
    .samples (samples),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_p   (mul_p)
  );

endmodule
